@@ hw/rtl/rac_pkg.sv @@
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types and constants of the lagged log-return correlation unit.
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int MAX_SERIES_LEN  = 4096;
    localparam int PRICE_FRAC_BITS = 16;
    localparam int LOG_FRAC        = 24;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef struct packed {
        logic [31:0] price;
        logic        price_missing;
        logic        last_in_series;
    } t_in;

    typedef struct packed {
        logic signed [31:0] correlation;
        logic               corr_valid;
        logic [12:0]        pair_total;
    } t_out;

    typedef struct packed {
        t_in  data;
        logic ok;
    } t_q_item;

endpackage

@@ hw/rtl/rac_front.sv @@
// ----------------------------------------------------------------------------
// rac_front
// Accepts samples, marks them valid or invalid and queues them (two deep).
// ----------------------------------------------------------------------------
module rac_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rac_pkg::t_in     i_in,
    output logic             o_q_valid,
    output rac_pkg::t_q_item o_q_item,
    input  logic             i_q_pop
);
    import rac_pkg::*;

    t_q_item    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_q_item    item;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rp];

    always_comb begin
        item.data = i_in;
        item.ok   = !i_in.price_missing && (i_in.price != 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule

@@ hw/rtl/rac_back.sv @@
// ----------------------------------------------------------------------------
// rac_back
// Sequencer: fixed-point log, running sums and end-of-series correlation.
// ----------------------------------------------------------------------------
module rac_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  rac_pkg::t_q_item i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rac_pkg::t_out    o_out
);
    import rac_pkg::*;

    localparam logic [4:0] DIV_STEPS = 5'd30;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_LOG, S_LN, S_LN2, S_UPD, S_ACC, S_HIST, S_MUL,
        S_CHK, S_SHR, S_SQRT, S_DEN, S_SAT, S_DIV, S_DONE
    } t_state;

    t_state r_state;

    // series state
    logic [31:0]  r_older, r_newer;
    logic [1:0]   r_hv;
    logic [47:0]  r_sret, r_sabs;
    logic [63:0]  r_sxx, r_syy, r_sxy;
    logic [12:0]  r_cnt;

    // working registers
    logic         r_ok, r_last;
    logic [31:0]  r_price;
    logic [4:0]   r_k;
    logic [31:0]  r_m;
    logic [23:0]  r_f;
    logic [4:0]   r_li;
    logic         r_lneg;
    logic [63:0]  r_prod;
    logic [31:0]  r_cur;
    logic signed [33:0] r_x, r_y;
    logic [2:0]   r_mi;
    logic [1:0]   r_ph;
    logic [127:0] r_acc, r_dx, r_dy, r_c;
    logic         r_cneg;
    logic [63:0]  r_vx, r_vy, r_rx, r_ry, r_bit;
    logic [63:0]  r_den, r_rem;
    logic [30:0]  r_q;
    logic [4:0]   r_dc;
    logic         r_res_ok;
    logic         r_out_valid;
    t_out         r_out;

    // combinational helpers
    logic [4:0]   k_enc;
    logic [63:0]  m_sq;
    logic [32:0]  m_next;
    logic signed [31:0] l_val;
    logic [31:0]  l_mag;
    logic [63:0]  r_round;
    logic [31:0]  r_fix;
    logic signed [33:0] x_new, y_diff, y_new, ma, mb;
    logic signed [67:0] acc_p;
    logic [63:0]  sx64, sx_mag, sxy_mag, n64, opa, opb;
    logic         op_neg;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [6:0]   shamt;
    logic [127:0] acc_next, term;
    logic         nx, ny;
    logic [1:0]   c_sh;
    logic [63:0]  tx, ty, rem2;
    logic         out_free;
    logic         do_pair;

    always_comb begin
        k_enc = 5'd0;
        for (int i = 1; i < 32; i++) begin
            if (r_price[i]) k_enc = 5'(i);
        end
    end

    assign m_sq   = 64'(r_m) * 64'(r_m);
    assign m_next = m_sq[63:31];

    assign l_val   = (32'(signed'({1'b0, r_k})) - 32'(PRICE_FRAC_BITS)) * (32'sd1 <<< LOG_FRAC)
                   + 32'(signed'({1'b0, r_f}));
    assign l_mag   = l_val[31] ? 32'(-l_val) : 32'(l_val);
    assign r_round = (r_prod + (64'd1 << 35)) >> 36;
    assign r_fix   = r_lneg ? 32'(-r_round[31:0]) : r_round[31:0];

    assign x_new  = 34'(signed'(r_newer)) - 34'(signed'(r_older));
    assign y_diff = 34'(signed'(r_cur)) - 34'(signed'(r_newer));
    assign y_new  = y_diff[33] ? -y_diff : y_diff;
    assign do_pair = r_ok && (r_hv == 2'b11) && (r_cnt < 13'(MAX_SERIES_LEN));

    assign ma    = (r_mi == 3'd1) ? r_y : r_x;
    assign mb    = (r_mi == 3'd0) ? r_x : r_y;
    assign acc_p = 68'(ma) * 68'(mb);

    assign sx64    = {{16{r_sret[47]}}, r_sret};
    assign sx_mag  = sx64[63] ? -sx64 : sx64;
    assign sxy_mag = r_sxy[63] ? -r_sxy : r_sxy;
    assign n64     = {51'd0, r_cnt};

    always_comb begin
        unique case (r_mi)
            3'd0:    begin opa = n64;    opb = r_sxx;   op_neg = 1'b0;      end
            3'd1:    begin opa = sx_mag; opb = sx_mag;  op_neg = 1'b0;      end
            3'd2:    begin opa = n64;    opb = r_syy;   op_neg = 1'b0;      end
            3'd3:    begin opa = {16'd0, r_sabs}; opb = {16'd0, r_sabs}; op_neg = 1'b0; end
            3'd4:    begin opa = n64;    opb = sxy_mag; op_neg = r_sxy[63]; end
            default: begin opa = sx_mag; opb = {16'd0, r_sabs}; op_neg = sx64[63]; end
        endcase
    end

    assign pa       = r_ph[1] ? opa[63:32] : opa[31:0];
    assign pb       = r_ph[0] ? opb[63:32] : opb[31:0];
    assign pp       = 64'(pa) * 64'(pb);
    assign shamt    = {({1'b0, r_ph[1]} + {1'b0, r_ph[0]}), 5'd0};
    assign acc_next = r_acc + ({64'd0, pp} << shamt);
    assign term     = op_neg ? -acc_next : acc_next;

    assign nx   = (r_dx[127:62] != '0);
    assign ny   = (r_dy[127:62] != '0);
    assign c_sh = {1'b0, nx} + {1'b0, ny};

    assign tx   = r_rx + r_bit;
    assign ty   = r_ry + r_bit;
    assign rem2 = {r_rem[62:0], 1'b0};

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_older     <= '0;
            r_newer     <= '0;
            r_hv        <= '0;
            r_sret      <= '0;
            r_sabs      <= '0;
            r_sxx       <= '0;
            r_syy       <= '0;
            r_sxy       <= '0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ok    <= i_q_item.ok;
                        r_last  <= i_q_item.data.last_in_series;
                        r_price <= i_q_item.data.price;
                        r_cur   <= '0;
                        r_state <= i_q_item.ok ? S_NORM : S_UPD;
                        r_li    <= 5'(LOG_FRAC - 1);
                        r_f     <= '0;
                        r_k     <= 5'd31;
                    end
                end
                S_NORM: begin
                    r_k     <= k_enc;
                    r_m     <= r_price << (5'd31 - k_enc);
                    r_state <= S_LOG;
                end
                S_LOG: begin
                    if (m_next[32]) begin
                        r_m        <= m_next[32:1];
                        r_f[r_li]  <= 1'b1;
                    end else begin
                        r_m <= m_next[31:0];
                    end
                    r_li <= r_li - 5'd1;
                    if (r_li == 5'd0) r_state <= S_LN;
                end
                S_LN: begin
                    r_prod  <= 64'(l_mag) * 64'(LN2_Q32);
                    r_lneg  <= l_val[31];
                    r_state <= S_LN2;
                end
                S_LN2: begin
                    r_cur   <= r_fix;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_x     <= x_new;
                    r_y     <= y_new;
                    r_mi    <= 3'd0;
                    r_state <= do_pair ? S_ACC : S_HIST;
                end
                S_ACC: begin
                    unique case (r_mi)
                        3'd0: begin
                            r_sret <= r_sret + 48'(r_x);
                            r_sabs <= r_sabs + 48'(r_y);
                            r_sxx  <= r_sxx + acc_p[63:0];
                        end
                        3'd1: r_syy <= r_syy + acc_p[63:0];
                        default: begin
                            r_sxy   <= r_sxy + acc_p[63:0];
                            r_cnt   <= r_cnt + 13'd1;
                            r_state <= S_HIST;
                        end
                    endcase
                    r_mi <= r_mi + 3'd1;
                end
                S_HIST: begin
                    r_older <= r_newer;
                    r_newer <= r_cur;
                    r_hv    <= {r_hv[0], r_ok};
                    r_mi    <= 3'd0;
                    r_ph    <= 2'd0;
                    r_acc   <= '0;
                    r_q     <= '0;
                    r_cneg  <= 1'b0;
                    r_res_ok <= 1'b0;
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_cnt < 13'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_ph  <= r_ph + 2'd1;
                    r_acc <= (r_ph == 2'd3) ? '0 : acc_next;
                    if (r_ph == 2'd3) begin
                        unique case (r_mi)
                            3'd0:    r_dx <= term;
                            3'd1:    r_dx <= r_dx - term;
                            3'd2:    r_dy <= term;
                            3'd3:    r_dy <= r_dy - term;
                            3'd4:    r_c  <= term;
                            default: r_c  <= r_c - term;
                        endcase
                        r_mi <= r_mi + 3'd1;
                        if (r_mi == 3'd5) r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_dx[127] || r_dx == '0 || r_dy[127] || r_dy == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cneg  <= r_c[127];
                        r_c     <= r_c[127] ? -r_c : r_c;
                        r_state <= S_SHR;
                    end
                end
                S_SHR: begin
                    if (!nx && !ny) begin
                        r_vx    <= r_dx[63:0];
                        r_vy    <= r_dy[63:0];
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end else begin
                        if (nx) r_dx <= r_dx >> 2;
                        if (ny) r_dy <= r_dy >> 2;
                        r_c <= r_c >> c_sh;
                    end
                end
                S_SQRT: begin
                    if (r_vx >= tx) begin
                        r_vx <= r_vx - tx;
                        r_rx <= (r_rx >> 1) + r_bit;
                    end else begin
                        r_rx <= r_rx >> 1;
                    end
                    if (r_vy >= ty) begin
                        r_vy <= r_vy - ty;
                        r_ry <= (r_ry >> 1) + r_bit;
                    end else begin
                        r_ry <= r_ry >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den   <= 64'(r_rx[31:0]) * 64'(r_ry[31:0]);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_res_ok <= 1'b1;
                    if (r_c[127:64] != '0 || r_c[63:0] >= r_den) begin
                        r_q     <= 31'd1 << 30;
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= r_c[63:0];
                        r_q     <= '0;
                        r_dc    <= DIV_STEPS;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem2 >= r_den) begin
                        r_rem <= rem2 - r_den;
                        r_q   <= {r_q[29:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_q   <= {r_q[29:0], 1'b0};
                    end
                    r_dc <= r_dc - 5'd1;
                    if (r_dc == 5'd1) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.correlation <= r_cneg ? -signed'({1'b0, r_q})
                                                    : signed'({1'b0, r_q});
                        r_out.corr_valid  <= r_res_ok;
                        r_out.pair_total  <= r_cnt;
                        r_older <= '0;
                        r_newer <= '0;
                        r_hv    <= '0;
                        r_sret  <= '0;
                        r_sabs  <= '0;
                        r_sxx   <= '0;
                        r_syy   <= '0;
                        r_sxy   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 13'(MAX_SERIES_LEN)) else $error("pair count beyond limit");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_den != '0) else $error("zero divisor");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.corr_valid |-> r_out.correlation == '0)
        else $error("invalid result with non-zero correlation");

endmodule

@@ hw/rtl/return_absnext_correlation_unit.sv @@
// ----------------------------------------------------------------------------
// return_absnext_correlation_unit
// Pearson correlation of log returns against the absolute next log return.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one price sample per
// transaction. Output channel: o_out_valid / i_out_stall carry one result
// transaction per series, on the sample marked last_in_series.
// A two-deep queue parts the front from the sequencer, so samples are taken
// while the sequencer works or a result waits.
// Per sample: a valid price that completes a window passes normalise, the
// 24 squaring steps of the log on one 32x32 multiplier, two rounding steps,
// then 3 accumulate steps; a valid price that does not skips the accumulate
// steps, and an invalid one skips both the log and the accumulate steps.
// At the end of a series: partial products on a 32x32 multiplier, shifts,
// square roots and a divide that a saturated result skips.
// Reset clears all series state and both channels; no clearing pass.
// A stalled result holds in the output register; the sequencer waits with
// the next result until it is taken, and the queue then fills and stalls.
// ----------------------------------------------------------------------------
module return_absnext_correlation_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rac_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rac_pkg::t_out o_out
);
    import rac_pkg::*;

    logic    q_valid;
    logic    q_pop;
    t_q_item q_item;

    rac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    rac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams price series into the correlation unit and compares each result
// transaction with a predicted value: directed table first, then random
// series, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import rac_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int N_LONG      = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 400;

    typedef struct {
        logic [31:0] price;
        logic        missing;
        logic        last;
        logic        fixed;
        t_out        res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    return_absnext_correlation_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // predictor state
    logic signed [31:0] older_lp, newer_lp;
    logic [1:0]         hist_ok;
    logic [47:0]        acc_ret, acc_abs;
    logic [63:0]        acc_ret_sq, acc_abs_sq, acc_cross;
    logic [12:0]        n_pairs;

    t_out   expected_corr_q[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    logic   quiet;
    t_row   rows[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] ln_q20(input logic [31:0] p);
        int          k;
        logic [63:0] m;
        logic [23:0] f;
        logic signed [63:0] lg;
        logic [63:0] mag, r;
        k = 31;
        while (k > 0 && p[k] == 1'b0) k--;
        m = 64'(p) << (31 - k);
        f = '0;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                f[i] = 1'b1;
            end
        end
        lg = (64'(k) << 24) + 64'(f) - (64'(PRICE_FRAC_BITS) << 24);
        mag = lg[63] ? -lg : lg;
        r = (mag * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
        if (lg[63]) r = -r;
        return r[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_out pearson_result();
        t_out r;
        logic signed [127:0] sx, sy, dx, dy, c;
        logic [127:0] cm;
        logic [63:0]  den, q;
        int           s;
        logic         cneg;
        r = '0;
        r.pair_total = n_pairs;
        if (n_pairs < 2) return r;
        sx = 128'(signed'(acc_ret));
        sy = 128'(acc_abs);
        dx = 128'(n_pairs) * 128'(acc_ret_sq) - sx * sx;
        dy = 128'(n_pairs) * 128'(acc_abs_sq) - sy * sy;
        c  = 128'(n_pairs) * 128'(signed'(acc_cross)) - sx * sy;
        if (dx <= 0 || dy <= 0) return r;
        cneg = c < 0;
        cm = cneg ? -c : c;
        s = 0;
        while (dx >= (128'd1 << 62)) begin dx = dx >>> 2; s++; end
        while (dy >= (128'd1 << 62)) begin dy = dy >>> 2; s++; end
        cm = cm >> s;
        den = floor_sqrt(dx[63:0]) * floor_sqrt(dy[63:0]);
        if (cm >= 128'(den)) q = 64'd1 << 30;
        else q = 64'((cm << 30) / 128'(den));
        if (cneg) q = -q;
        r.correlation = q[31:0];
        r.corr_valid  = 1'b1;
        return r;
    endfunction

    task automatic clear_series();
        older_lp = 0; newer_lp = 0; hist_ok = 0;
        acc_ret = 0; acc_abs = 0; acc_ret_sq = 0; acc_abs_sq = 0; acc_cross = 0;
        n_pairs = 0;
    endtask

    task automatic predict_sample(input t_in s, output logic got, output t_out r);
        logic               ok;
        logic signed [31:0] cur;
        logic signed [63:0] x, y;
        ok  = !s.price_missing && s.price != 0;
        cur = ok ? ln_q20(s.price) : '0;
        got = 1'b0;
        r   = '0;
        if (ok && hist_ok == 2'b11 && n_pairs < MAX_SERIES_LEN) begin
            x = 64'(newer_lp) - 64'(older_lp);
            y = 64'(cur) - 64'(newer_lp);
            if (y < 0) y = -y;
            acc_ret    = acc_ret + x[47:0];
            acc_abs    = acc_abs + y[47:0];
            acc_ret_sq = acc_ret_sq + x * x;
            acc_abs_sq = acc_abs_sq + y * y;
            acc_cross  = acc_cross + x * y;
            n_pairs++;
        end
        older_lp = newer_lp;
        newer_lp = cur;
        hist_ok  = {hist_ok[0], ok};
        if (s.last_in_series) begin
            got = 1'b1;
            r = pearson_result();
            clear_series();
        end
    endtask

    task automatic add_row(input logic [31:0] p, input logic mi, input logic la,
                           input logic fx = 1'b0, input t_out res = '0);
        t_row w;
        w.price = p; w.missing = mi; w.last = la; w.fixed = fx; w.res = res;
        rows.push_back(w);
    endtask

    task automatic send(input t_row w);
        t_in  s;
        logic got;
        t_out r;
        s = '{price: w.price, price_missing: w.missing, last_in_series: w.last};
        while (!quiet && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= s;
        do @(posedge i_clk); while (o_in_stall);
        predict_sample(s, got, r);
        if (got) expected_corr_q.push_back(w.fixed ? w.res : r);
    endtask

    task automatic random_series(input int len);
        int mode;
        logic [31:0] base, p;
        mode = $urandom_range(9);
        base = $urandom_range(32'h0100_0000, 32'h0001_0000);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0:       p = $urandom();
                1:       p = $urandom_range(3);
                default: begin
                    p = base + $urandom_range(base >> 4) - (base >> 5);
                    base = p;
                end
            endcase
            add_row(p, $urandom_range(19) == 0, i == len - 1);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        i_out_stall <= !quiet && i_rst_n && ($urandom_range(99) < 10);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_corr_q.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected transaction %p", o_out);
            end else begin
                if (o_out !== expected_corr_q[0]) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch exp %p got %p", expected_corr_q[0], o_out);
                end
                void'(expected_corr_q.pop_front());
            end
        end
    end

    initial begin
        t_out u0, sat_p;
        int   wait_n, sent;
        u0 = '0;
        quiet = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in = '0;
        clear_series();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lone last sample, then a series with a single pair
        add_row(32'h0001_0000, 1'b0, 1'b1, 1'b1, u0);
        add_row(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_row(32'h0000_0001, 1'b0, 1'b0);
        add_row(32'hFFFF_FFFF, 1'b0, 1'b1);
        // invalid samples break windows
        add_row(32'h0002_0000, 1'b0, 1'b0);
        add_row(32'h0000_0000, 1'b0, 1'b0);
        add_row(32'h0003_0000, 1'b0, 1'b0);
        add_row(32'h0004_0000, 1'b1, 1'b0);
        add_row(32'h0005_0000, 1'b0, 1'b1, 1'b1, u0);
        // constant prices: zero variance
        repeat (4) add_row(32'h0001_0000, 1'b0, 1'b0);
        add_row(32'h0001_0000, 1'b0, 1'b1);
        // alternating prices, saturation and ordinary rows
        add_row(32'h0001_0000, 1'b0, 1'b0);
        add_row(32'h0002_0000, 1'b0, 1'b0);
        add_row(32'h0004_0000, 1'b0, 1'b0);
        add_row(32'h0001_0000, 1'b0, 1'b0);
        add_row(32'h0002_0000, 1'b0, 1'b0);
        add_row(32'h8000_0000, 1'b0, 1'b1);
        add_row(32'h0000_0003, 1'b0, 1'b0);
        add_row(32'h7FFF_FFFF, 1'b1, 1'b0);
        add_row(32'h1234_5678, 1'b0, 1'b1);
        // longer periodic series
        for (int i = 0; i < N_LONG; i++)
            add_row(32'h0001_0000 + (i % 7) * 32'h1357, 1'b0, i == N_LONG - 1);

        foreach (rows[i]) send(rows[i]);
        rows.delete();

        sent = 0;
        while (sent < N_RANDOM) begin
            quiet = (sent > 400 && sent < 550);
            random_series($urandom_range(1, 24));
            sent += rows.size();
            foreach (rows[i]) send(rows[i]);
            rows.delete();
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        wait_n = 0;
        while (expected_corr_q.size() != 0 && wait_n < 200000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_corr_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/rac_pkg.sv
hw/rtl/rac_front.sv
hw/rtl/rac_back.sv
hw/rtl/return_absnext_correlation_unit.sv
tb/tb_top.sv
